### hw/rtl/apr_pkg.sv
// shared constants, types and state encoding for the aging presence roster
package apr_pkg;

  localparam int ENTRIES    = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W    = 6;
  localparam int ID_W       = 32;
  localparam int TIME_W     = 32;
  localparam int ENTRY_W    = ID_W + TIME_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(600);

  // register index taken from paddr word bits
  localparam logic REG_WINDOW = 1'b0;

  localparam logic ACT_HEARD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } apr_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } apr_cmd_t;

  typedef struct packed {
    logic scan_done;
  } apr_sts_t;

endpackage

### hw/rtl/apr_regs.sv
// configuration register block: expiry window behind an apb-style port
module apr_regs
  import apr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [TIME_W-1:0]     window
);

  logic [TIME_W-1:0] window_r;
  logic [TIME_W-1:0] window_nxt;
  logic              hit_window;

  assign pready     = 1'b1;
  assign hit_window = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW);

  always_comb begin
    window_nxt = window_r;
    if (psel && penable && pwrite && pready && hit_window) begin
      window_nxt = pwdata[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  assign prdata = hit_window ? CFG_DATA_W'(window_r) : '0;
  assign window = window_r;

endmodule

### hw/rtl/apr_ctrl.sv
// controller state machine: load, scan/compact, update
module apr_ctrl
  import apr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  apr_sts_t sts,
  output apr_cmd_t cmd,
  output logic     busy
);

  apr_state_t state_r;
  apr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/apr_dp.sv
// datapath: entry memory, compaction scan, match and oldest tracking, counters
module apr_dp
  import apr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  apr_cmd_t           cmd,
  output apr_sts_t           sts,
  input  logic [TIME_W-1:0]  window,
  input  logic               in_action,
  input  logic [ID_W-1:0]    in_station_id,
  input  logic [TIME_W-1:0]  in_now_seconds,
  output logic               out_strobe,
  output logic [COUNT_W-1:0] out_online_count,
  output logic [COUNT_W-1:0] out_peak_count
);

  logic [ENTRY_W-1:0] mem [ENTRIES];

  logic               action_r;
  logic [ID_W-1:0]    id_r;
  logic [TIME_W-1:0]  now_r;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] peak_r, peak_nxt;
  logic [COUNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [COUNT_W-1:0] kept_r, kept_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [ENTRY_W-1:0] rd_data_r;
  logic               match_r, match_nxt;
  logic [IDX_W-1:0]   match_idx_r, match_idx_nxt;
  logic               min_vld_r, min_vld_nxt;
  logic [TIME_W-1:0]  min_time_r, min_time_nxt;
  logic [IDX_W-1:0]   min_idx_r, min_idx_nxt;
  logic               strobe_r;

  logic               rd_issue;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_time;
  logic [TIME_W-1:0]  age;
  logic               alive;
  logic [COUNT_W-1:0] kept_p1;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  assign rd_issue = cmd.scan && (rd_idx_r < count_r);
  assign rd_id    = rd_data_r[ENTRY_W-1:TIME_W];
  assign rd_time  = rd_data_r[TIME_W-1:0];
  // wrap-safe age
  assign age      = now_r - rd_time;
  assign alive    = age < window;
  assign kept_p1  = kept_r + COUNT_W'(1);

  assign sts.scan_done = !(rd_idx_r < count_r) && !rd_vld_r;

  always_comb begin
    count_nxt     = count_r;
    peak_nxt      = peak_r;
    rd_idx_nxt    = rd_idx_r;
    kept_nxt      = kept_r;
    rd_vld_nxt    = 1'b0;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    min_vld_nxt   = min_vld_r;
    min_time_nxt  = min_time_r;
    min_idx_nxt   = min_idx_r;
    wr_en         = 1'b0;
    wr_addr       = kept_r[IDX_W-1:0];
    wr_data       = rd_data_r;

    if (cmd.load) begin
      rd_idx_nxt  = '0;
      kept_nxt    = '0;
      match_nxt   = 1'b0;
      min_vld_nxt = 1'b0;
    end

    if (cmd.scan) begin
      if (rd_issue) begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = rd_idx_r + COUNT_W'(1);
      end
      // survivors move down to slot kept, which was already read
      if (rd_vld_r && alive) begin
        wr_en    = 1'b1;
        kept_nxt = kept_p1;
        if (!match_r && (rd_id == id_r)) begin
          match_nxt     = 1'b1;
          match_idx_nxt = kept_r[IDX_W-1:0];
        end
        if (!min_vld_r || (rd_time < min_time_r)) begin
          min_vld_nxt  = 1'b1;
          min_time_nxt = rd_time;
          min_idx_nxt  = kept_r[IDX_W-1:0];
        end
      end
    end

    if (cmd.update) begin
      count_nxt = kept_r;
      wr_data   = {id_r, now_r};
      priority if (action_r == ACT_QUERY) begin
        wr_en = 1'b0;
      end else if (match_r) begin
        wr_en   = 1'b1;
        wr_addr = match_idx_r;
      end else if (kept_r == COUNT_W'(ENTRIES)) begin
        wr_en   = 1'b1;
        wr_addr = min_idx_r;
      end else begin
        wr_en     = 1'b1;
        count_nxt = kept_p1;
        if (kept_p1 > peak_r) begin
          peak_nxt = kept_p1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      id_r     <= in_station_id;
      now_r    <= in_now_seconds;
    end
    match_idx_r <= match_idx_nxt;
    min_time_r  <= min_time_nxt;
    min_idx_r   <= min_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      peak_r    <= '0;
      rd_idx_r  <= '0;
      kept_r    <= '0;
      rd_vld_r  <= 1'b0;
      match_r   <= 1'b0;
      min_vld_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      peak_r    <= peak_nxt;
      rd_idx_r  <= rd_idx_nxt;
      kept_r    <= kept_nxt;
      rd_vld_r  <= rd_vld_nxt;
      match_r   <= match_nxt;
      min_vld_r <= min_vld_nxt;
      strobe_r  <= cmd.update;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_online_count = count_r;
  assign out_peak_count   = peak_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(ENTRIES)) else $error("live count above capacity");

  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= count_r) else $error("live count above peak");

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= rd_idx_r) else $error("compaction write ahead of read");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r) else $error("result beat repeated");
`endif

endmodule

### hw/rtl/aging_presence_roster.sv
// top level of the aging presence roster
//
//  channel   ports                                    handshake
//  input     in_action, in_station_id, in_now_seconds start & !busy
//  result    out_online_count, out_peak_count         out_strobe, one cycle
//  config    psel penable pwrite paddr pwdata prdata  apb write, pready high
//
// the result beat follows a compaction scan over every stored entry, which reads
// one entry per cycle through the single memory read port.
// busy is high from the cycle after accept until the result beat.
// synchronous active-low reset empties the list, zeroes the peak and sets the
// window to 600; no clearing pass is needed.
// the result beat cannot be stalled; a new item may start in the beat cycle.
module aging_presence_roster
  import apr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_action,
  input  logic [ID_W-1:0]       in_station_id,
  input  logic [TIME_W-1:0]     in_now_seconds,
  output logic                  out_strobe,
  output logic [COUNT_W-1:0]    out_online_count,
  output logic [COUNT_W-1:0]    out_peak_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  apr_cmd_t          cmd;
  apr_sts_t          sts;
  logic [TIME_W-1:0] window;

  apr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  apr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  apr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .window           (window),
    .in_action        (in_action),
    .in_station_id    (in_station_id),
    .in_now_seconds   (in_now_seconds),
    .out_strobe       (out_strobe),
    .out_online_count (out_online_count),
    .out_peak_count   (out_peak_count)
  );

endmodule

### test/roster_count_monitor.sv
// checker for the aging presence roster: mirrors the station list and compares each count beat
`timescale 1ns / 1ps
module roster_count_monitor
  import apr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_action,
  input  logic [ID_W-1:0]       in_station_id,
  input  logic [TIME_W-1:0]     in_now_seconds,
  input  logic                  out_strobe,
  input  logic [COUNT_W-1:0]    out_online_count,
  input  logic [COUNT_W-1:0]    out_peak_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    mismatch_cnt,
  output int                    counts_owed,
  output int                    beats_seen,
  output int                    evictions
);

  typedef struct packed {
    logic [COUNT_W-1:0] online;
    logic [COUNT_W-1:0] peak;
  } roster_counts_t;

  logic [ID_W-1:0]   seen_ids   [ENTRIES];
  logic [TIME_W-1:0] seen_times [ENTRIES];
  int unsigned       on_air;
  int unsigned       high_mark;
  logic [TIME_W-1:0] window;
  roster_counts_t    counts_due [$];

  initial begin
    mismatch_cnt = 0;
    counts_owed  = 0;
    beats_seen   = 0;
    evictions    = 0;
  end

  task automatic flag(input string msg);
    if (mismatch_cnt < 10) begin
      $display("%t: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  // ages out stale stations, then logs the heard one, and queues the counts it yields
  task automatic log_station(input logic act, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] now);
    int unsigned       kept;
    int unsigned       oldest;
    bit                found;
    logic [TIME_W-1:0] age;
    kept  = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < on_air; i++) begin
      age = now - seen_times[i];
      if (age < window) begin
        seen_ids[kept]   = seen_ids[i];
        seen_times[kept] = seen_times[i];
        kept++;
      end
    end
    on_air = kept;
    if (act == ACT_HEARD) begin
      for (int unsigned i = 0; i < on_air; i++) begin
        if (!found && seen_ids[i] == id) begin
          seen_times[i] = now;
          found = 1'b1;
        end
      end
      if (!found && on_air >= ENTRIES) begin
        // full list: overwrite smallest raw time, first one on ties
        oldest = 0;
        for (int unsigned i = 1; i < ENTRIES; i++) begin
          if (seen_times[i] < seen_times[oldest]) oldest = i;
        end
        seen_ids[oldest]   = id;
        seen_times[oldest] = now;
        evictions++;
      end else if (!found) begin
        seen_ids[on_air]   = id;
        seen_times[on_air] = now;
        on_air++;
        if (on_air > high_mark) high_mark = on_air;
      end
    end
    counts_due.push_back('{online: COUNT_W'(on_air), peak: COUNT_W'(high_mark)});
  endtask

  always @(posedge clk) begin
    roster_counts_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        seen_ids[i]   = '0;
        seen_times[i] = '0;
      end
      on_air    = 0;
      high_mark = 0;
      window    = WINDOW_RESET;
      counts_due.delete();
      counts_owed <= 0;
    end else begin
      // result beat belongs to an older item than one accepted at this edge
      if (out_strobe) begin
        beats_seen++;
        if (counts_due.size() == 0) begin
          flag($sformatf("unexpected beat online=%0d peak=%0d",
                         out_online_count, out_peak_count));
        end else begin
          want = counts_due.pop_front();
          if (out_online_count !== want.online || out_peak_count !== want.peak) begin
            flag($sformatf("beat %0d: online exp %0d got %0d, peak exp %0d got %0d",
                           beats_seen, want.online, out_online_count,
                           want.peak, out_peak_count));
          end
        end
      end
      if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_WINDOW) begin
        if (pwrite) begin
          window = pwdata[TIME_W-1:0];
        end else if (prdata[TIME_W-1:0] !== window) begin
          flag($sformatf("window read exp %0d got %0d", window, prdata));
        end
      end
      if (start && !busy) begin
        log_station(in_action, in_station_id, in_now_seconds);
      end
      counts_owed <= counts_due.size();
    end
  end

endmodule

### test/aging_presence_roster_tb.sv
// testbench top for the aging presence roster: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module aging_presence_roster_tb;
  import apr_pkg::*;

  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 250;
  localparam int ID_POOL        = 40;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = CFG_ADDR_W'({REG_WINDOW, 2'b00});
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE  = CFG_ADDR_W'({~REG_WINDOW, 2'b00});

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_action = ACT_HEARD;
  logic [ID_W-1:0]       in_station_id = '0;
  logic [TIME_W-1:0]     in_now_seconds = '0;
  logic                  out_strobe;
  logic [COUNT_W-1:0]    out_online_count;
  logic [COUNT_W-1:0]    out_peak_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int                    mismatch_cnt;
  int                    counts_owed;
  int                    beats_seen;
  int                    evictions;
  int                    cycle_cnt = 0;
  int                    items_sent = 0;
  bit                    quiet = 1'b0;
  logic [ID_W-1:0]       id_pool [ID_POOL];
  logic [TIME_W-1:0]     windows [PHASES];

  always #2 clk = ~clk;

  aging_presence_roster u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_station_id    (in_station_id),
    .in_now_seconds   (in_now_seconds),
    .out_strobe       (out_strobe),
    .out_online_count (out_online_count),
    .out_peak_count   (out_peak_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  roster_count_monitor u_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_station_id    (in_station_id),
    .in_now_seconds   (in_now_seconds),
    .out_strobe       (out_strobe),
    .out_online_count (out_online_count),
    .out_peak_count   (out_peak_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatch_cnt     (mismatch_cnt),
    .counts_owed      (counts_owed),
    .beats_seen       (beats_seen),
    .evictions        (evictions)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == TIMEOUT_CYCLES) begin
      $display("aging_presence_roster_tb failed");
      $finish;
    end
  end

  // holds start until the item is accepted; a gap of zero keeps start high for the next one
  task automatic send_item(input logic act, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] now, input int gap);
    start          <= 1'b1;
    in_action      <= act;
    in_station_id  <= id;
    in_now_seconds <= now;
    do @(posedge clk); while (busy);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (counts_owed != 0 || busy);
  endtask

  // idles after the access so a following access starts on a fresh edge
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) pick_gap = 0;
    else if (r < 82) pick_gap = $urandom_range(1, 3);
    else if (r < 96) pick_gap = $urandom_range(4, 14);
    else pick_gap = $urandom_range(20, 60);
  endfunction

  // mostly steady clock advance scaled to the window, with repeats, jumps and steps back
  function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] now,
                                                  input logic [TIME_W-1:0] win);
    logic [TIME_W-1:0] cap;
    int unsigned       r;
    cap = (win >> 3) + TIME_W'(2);
    r   = $urandom_range(0, 99);
    if (r < 50) next_time = now + $urandom_range(0, cap);
    else if (r < 65) next_time = now;
    else if (r < 80) next_time = now + $urandom_range(0, win);
    else if (r < 90) next_time = $urandom;
    else next_time = now - $urandom_range(1, cap);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, ID_W - 1);
    if (r < 78) pick_id = id_pool[$urandom_range(0, ID_POOL - 1)];
    else if (r < 90) pick_id = $urandom;
    else if (r < 93) pick_id = '0;
    else if (r < 96) pick_id = '1;
    else if (r < 98) pick_id = ID_W'(1) << k;
    else pick_id = ~(ID_W'(1) << k);
  endfunction

  initial begin
    logic [TIME_W-1:0] now;
    logic              act;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = $urandom;
    windows = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd64, WINDOW_RESET, 32'd100000,
                32'd0, 32'd7};
    windows[6] = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of 600: expiry edge, refresh, wrap forward and time stepping back
    send_item(ACT_QUERY, 32'h0000_0000, 32'd0, 0);
    send_item(ACT_HEARD, 32'h0000_0000, 32'd0, 0);
    send_item(ACT_HEARD, 32'hFFFF_FFFF, 32'd0, 2);
    send_item(ACT_HEARD, 32'h0000_0000, 32'd599, 1);
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 32'd600, 0);
    send_item(ACT_HEARD, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 5);
    send_item(ACT_HEARD, 32'h5A5A_A5A5, 32'd5, 0);
    send_item(ACT_HEARD, 32'h0000_0001, 32'd3, 1);
    send_item(ACT_QUERY, 32'h0000_0000, 32'd4, 1);

    // write to the spare index must leave the window alone
    wait_idle();
    cfg_access(1'b1, ADDR_SPARE, 32'h0000_0000);
    cfg_access(1'b0, ADDR_WINDOW, '0);

    // zero window expires every stored entry on each item
    cfg_access(1'b1, ADDR_WINDOW, 32'd0);
    send_item(ACT_HEARD, 32'h0000_0007, 32'd10, 0);
    send_item(ACT_HEARD, 32'h0000_0007, 32'd10, 0);
    send_item(ACT_HEARD, 32'h1234_5678, 32'd10, 0);
    send_item(ACT_QUERY, 32'h0000_0007, 32'd10, 1);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      cfg_access(1'b1, ADDR_WINDOW, windows[p]);
      cfg_access(1'b0, ADDR_WINDOW, '0);
      now = p[0] ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 1000));
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 49) quiet = ($urandom_range(0, 3) == 0);
        act = ($urandom_range(0, 4) == 0) ? ACT_QUERY : ACT_HEARD;
        now = next_time(now, windows[p]);
        send_item(act, pick_id(), now, (k == PHASE_ITEMS - 1) ? 1 + pick_gap() : pick_gap());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("sent %0d items over %0d window settings, %0d count beats checked",
             items_sent, PHASES + 2, beats_seen);
    $display("full-list replacements seen: %0d", evictions);
    if (mismatch_cnt == 0 && counts_owed == 0) begin
      $display("aging_presence_roster_tb passed");
    end else begin
      $display("aging_presence_roster_tb failed");
    end
    $finish;
  end

endmodule

### aging_presence_roster.f
hw/rtl/apr_pkg.sv
hw/rtl/apr_regs.sv
hw/rtl/apr_ctrl.sv
hw/rtl/apr_dp.sv
hw/rtl/aging_presence_roster.sv
test/roster_count_monitor.sv
test/aging_presence_roster_tb.sv
